[design/ps2_mouse_packet_tracker_unit_assert.svh]
// assertion macros for the ps2 mouse packet tracker rtl
// no dependencies; included inside module bodies
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_ASSERT_SVH

// clocked assertion, masked while reset is high
`define PMT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define PMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/ps2mpt_pkg.sv]
// shared types and constants for the ps2 mouse packet tracker
// no dependencies
`default_nettype none

package ps2mpt_pkg;

   localparam int BYTE_BITS      = 8;
   localparam int LIMIT_BITS     = 12;
   localparam int POS_BITS       = 12;
   localparam int DELTA_BITS     = 9;
   localparam int STEP_BITS      = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 48;

   // bit positions in the first packet byte
   localparam int BIT_LEFT   = 0;
   localparam int BIT_RIGHT  = 1;
   localparam int BIT_MIDDLE = 2;
   localparam int BIT_SYNC   = 3;
   localparam int BIT_X_SIGN = 4;
   localparam int BIT_Y_SIGN = 5;
   localparam int BIT_X_OVF  = 6;
   localparam int BIT_Y_OVF  = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_LIMIT = 1'b1;

   localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = 12'd1024;
   localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = 12'd768;

   // bytes held so far of the open packet
   localparam logic [1:0] CNT_NONE  = 2'd0;
   localparam logic [1:0] CNT_FIRST = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;

   typedef struct packed {
      logic [BYTE_BITS-1:0] first;
      logic [BYTE_BITS-1:0] second;
      logic [BYTE_BITS-1:0] third;
   } packet_type;

   typedef struct packed {
      logic                         left_button;
      logic                         right_button;
      logic                         middle_button;
      logic                         x_overflow;
      logic                         y_overflow;
      logic signed [DELTA_BITS-1:0] delta_x;
      logic signed [DELTA_BITS-1:0] delta_y;
      logic [POS_BITS-1:0]          pos_x;
      logic [POS_BITS-1:0]          pos_y;
   } result_type;

endpackage

`default_nettype wire

[design/ps2mpt_assembler.sv]
// collects three mouse bytes into a packet, syncing on bit 3 of the first byte
// depends on ps2mpt_pkg
`default_nettype none

module ps2mpt_assembler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic [ps2mpt_pkg::BYTE_BITS-1:0] req_byte,
   output logic                                 req_ready,
   output ps2mpt_pkg::packet_type               pkt,
   output logic                                 pkt_valid,
   input  wire logic                            pkt_ready
);
   import ps2mpt_pkg::*;

   logic [1:0]           count_ff, count_in;
   logic [BYTE_BITS-1:0] first_ff, first_in;
   logic [BYTE_BITS-1:0] second_ff, second_in;
   packet_type           pkt_ff, pkt_in;
   logic                 pkt_valid_ff, pkt_valid_in;
   logic                 accept;

   // only a closing byte needs room in the packet register
   assign req_ready = (count_ff != CNT_TWO) || !pkt_valid_ff || pkt_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      count_in     = count_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      pkt_in       = pkt_ff;
      pkt_valid_in = pkt_valid_ff && !pkt_ready;
      if (accept) begin
         unique case (count_ff)
            CNT_FIRST: begin
               second_in = req_byte;
               count_in  = CNT_TWO;
            end
            CNT_TWO: begin
               pkt_in.first  = first_ff;
               pkt_in.second = second_ff;
               pkt_in.third  = req_byte;
               pkt_valid_in  = 1'b1;
               count_in      = CNT_NONE;
            end
            default: begin
               // unsynced bytes are dropped
               if (req_byte[BIT_SYNC]) begin
                  first_in = req_byte;
                  count_in = CNT_FIRST;
               end else begin
                  count_in = CNT_NONE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_NONE;
         pkt_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pkt_valid_ff <= pkt_valid_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      pkt_ff    <= pkt_in;
   end

   assign pkt       = pkt_ff;
   assign pkt_valid = pkt_valid_ff;

endmodule

`default_nettype wire

[design/ps2mpt_axis.sv]
// one cursor axis: add a signed step, clamp to 0..limit, hold on overflow
// depends on ps2mpt_pkg
`default_nettype none

module ps2mpt_axis #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                                   [COORD_BITS-1:0] pos,
   input  wire logic signed [ps2mpt_pkg::STEP_BITS-1:0]                 step,
   input  wire logic                                                    ovf,
   input  wire logic                                   [COORD_BITS-1:0] limit,
   output logic                                        [COORD_BITS-1:0] pos_next
);
   import ps2mpt_pkg::*;

   localparam int NW = COORD_BITS + 2;

   logic signed [NW-1:0] step_ext;
   logic signed [NW-1:0] pos_ext;
   logic signed [NW-1:0] limit_ext;
   logic signed [NW-1:0] sum;

   assign step_ext  = NW'(step);
   assign pos_ext   = $signed({2'b00, pos});
   assign limit_ext = $signed({2'b00, limit});
   assign sum       = pos_ext + step_ext;

   always_comb begin
      if (ovf) begin
         pos_next = pos;
      end else if (sum[NW-1]) begin
         pos_next = '0;
      end else if (sum > limit_ext) begin
         pos_next = limit;
      end else begin
         pos_next = sum[COORD_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

[design/ps2mpt_tracker.sv]
// decodes a packet, updates the cursor and holds the result for the output
// depends on ps2mpt_pkg, ps2mpt_axis, ps2_mouse_packet_tracker_unit_assert.svh
`default_nettype none

module ps2mpt_tracker #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ps2mpt_pkg::packet_type            pkt,
   input  wire logic                              pkt_valid,
   output logic                                   pkt_ready,
   input  wire logic [ps2mpt_pkg::LIMIT_BITS-1:0] x_limit,
   input  wire logic [ps2mpt_pkg::LIMIT_BITS-1:0] y_limit,
   output ps2mpt_pkg::result_type                 rsp,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready
);
   import ps2mpt_pkg::*;
   `include "ps2_mouse_packet_tracker_unit_assert.svh"

   logic [COORD_BITS-1:0]    cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]    cursor_y_ff, cursor_y_in;
   logic [COORD_BITS-1:0]    x_next, y_next;
   logic [COORD_BITS-1:0]    x_lim, y_lim;
   result_type               rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     take;
   logic                     xo, yo;
   logic signed [DELTA_BITS-1:0] dx, dy;
   logic signed [STEP_BITS-1:0]  step_x, step_y;

   assign pkt_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pkt_valid && pkt_ready;

   assign xo     = pkt.first[BIT_X_OVF];
   assign yo     = pkt.first[BIT_Y_OVF];
   assign dx     = $signed({pkt.first[BIT_X_SIGN], pkt.second});
   assign dy     = $signed({pkt.first[BIT_Y_SIGN], pkt.third});
   assign step_x = STEP_BITS'(dx);
   // screen y grows downward
   assign step_y = -STEP_BITS'(dy);

   assign x_lim = COORD_BITS'(x_limit);
   assign y_lim = COORD_BITS'(y_limit);

   ps2mpt_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .pos      (cursor_x_ff),
      .step     (step_x),
      .ovf      (xo),
      .limit    (x_lim),
      .pos_next (x_next)
   );

   ps2mpt_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .pos      (cursor_y_ff),
      .step     (step_y),
      .ovf      (yo),
      .limit    (y_lim),
      .pos_next (y_next)
   );

   always_comb begin
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         cursor_x_in          = x_next;
         cursor_y_in          = y_next;
         rsp_in.left_button   = pkt.first[BIT_LEFT];
         rsp_in.right_button  = pkt.first[BIT_RIGHT];
         rsp_in.middle_button = pkt.first[BIT_MIDDLE];
         rsp_in.x_overflow    = xo;
         rsp_in.y_overflow    = yo;
         rsp_in.delta_x       = dx;
         rsp_in.delta_y       = dy;
         rsp_in.pos_x         = POS_BITS'(x_next);
         rsp_in.pos_y         = POS_BITS'(y_next);
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `PMT_ASSERT(a_take_shows_result, clock, reset, take |=> rsp_valid_ff, "packet taken but no result")
   `PMT_ASSERT(a_cursor_idle, clock, reset, !take |=> ($stable(cursor_x_ff) && $stable(cursor_y_ff)), "cursor moved without a packet")
   `PMT_ASSERT(a_x_ovf_holds, clock, reset, (take && xo) |=> $stable(cursor_x_ff), "x moved on overflow")
   `PMT_ASSERT(a_x_in_range, clock, reset, (take && !xo) |=> (cursor_x_ff <= $past(x_lim)), "x beyond limit")
   `PMT_ASSERT(a_y_in_range, clock, reset, (take && !yo) |=> (cursor_y_ff <= $past(y_lim)), "y beyond limit")

endmodule

`default_nettype wire

[design/ps2_mouse_packet_tracker_unit.sv]
// ps2 mouse packet tracker: takes one mouse byte per transfer, gives one result per packet
// the closing byte of a packet is held in the packet register, then its result in the result register
// throughput: one byte per cycle, stalled only when a closing byte finds no room in the packet register
// with a result waiting and a packet queued behind it, only the next closing byte stalls
// reset (synchronous): drops any open packet and results, cursor to 0, limits to 1024 / 768
`default_nettype none

module ps2_mouse_packet_tracker_unit #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // fields from bit 0: data_byte[7:0]
   input  wire logic [ps2mpt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // fields from bit 0: left_button, right_button, middle_button, x_overflow,
   // y_overflow, delta_x[8:0], delta_y[8:0], pos_x[11:0], pos_y[11:0], zero pad
   output logic      [ps2mpt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_we,
   input  wire logic [ps2mpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ps2mpt_pkg::LIMIT_BITS-1:0]    csr_wdata
);
   import ps2mpt_pkg::*;

   logic [LIMIT_BITS-1:0] x_limit_ff, x_limit_in;
   logic [LIMIT_BITS-1:0] y_limit_ff, y_limit_in;
   packet_type            pkt;
   logic                  pkt_valid;
   logic                  pkt_ready;
   result_type            rsp;

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_X_LIMIT: x_limit_in = csr_wdata;
            CSR_Y_LIMIT: y_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
      end else begin
         x_limit_ff <= x_limit_in;
         y_limit_ff <= y_limit_in;
      end
   end

   ps2mpt_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_byte  (req_tdata[BYTE_BITS-1:0]),
      .req_ready (req_tready),
      .pkt       (pkt),
      .pkt_valid (pkt_valid),
      .pkt_ready (pkt_ready)
   );

   ps2mpt_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .pkt       (pkt),
      .pkt_valid (pkt_valid),
      .pkt_ready (pkt_ready),
      .x_limit   (x_limit_ff),
      .y_limit   (y_limit_ff),
      .rsp       (rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0,
                       rsp.pos_y,
                       rsp.pos_x,
                       rsp.delta_y,
                       rsp.delta_x,
                       rsp.y_overflow,
                       rsp.x_overflow,
                       rsp.middle_button,
                       rsp.right_button,
                       rsp.left_button};

endmodule

`default_nettype wire
